// ===== src/otde_pkg.sv =====
// Package for the object transform delta encoder.
// Holds the request codes, memory entry and job types, and small helper functions.
// No dependencies.
package otde_pkg;

  localparam int NUM_ENTRIES = 9;
  localparam int S_TDATA_W   = 128;
  localparam int CFG_AW      = 3;

  localparam logic [CFG_AW-1:0] REG_FOV   = 3'd0;
  localparam logic [7:0]        FOV_RESET = 8'd60;

  // floor(fov*256/360) == (fov*FOV_RECIP) >> FOV_SHIFT for every 8-bit fov.
  localparam logic [14:0] FOV_RECIP = 15'd23302;
  localparam int          FOV_SHIFT = 15;

  localparam logic [7:0] MARK_BYTE = 8'hFF;
  localparam logic [1:0] ESC_TAG   = 2'b11;

  typedef enum logic [1:0] {
    REQ_STAGE  = 2'd0,
    REQ_COMMIT = 2'd1,
    REQ_FRAME  = 2'd2,
    REQ_STREAM = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SZ_NONE = 2'd0,
    SZ_BYTE = 2'd1,
    SZ_HALF = 2'd2,
    SZ_WORD = 2'd3
  } size_t;

  typedef struct packed {
    logic                         vis;
    logic [31:0]                  px;
    logic [31:0]                  py;
    logic [31:0]                  pz;
    logic [NUM_ENTRIES-1:0][15:0] mat;
  } entry_t;

  typedef struct packed {
    logic                         is_commit;
    logic                         esc_need;
    logic [7:0]                   esc_byte;
    logic [7:0]                   hdr_byte;
    logic [1:0]                   masklen;
    logic [15:0]                  mask;
    logic [31:0]                  wx;
    logic [31:0]                  wy;
    logic [31:0]                  wz;
    logic                         wide;
    logic [NUM_ENTRIES-1:0][15:0] dm;
    logic [7:0]                   tail_byte;
  } job_t;

  function automatic logic [1:0] size_code(input logic signed [31:0] d);
    logic [1:0] c;
    if (d == 32'sd0) c = SZ_NONE;
    else if (d >= -32'sd127 && d <= 32'sd127) c = SZ_BYTE;
    else if (d >= -32'sd32767 && d <= 32'sd32767) c = SZ_HALF;
    else c = SZ_WORD;
    return c;
  endfunction

  function automatic logic [1:0] last_k(input logic [1:0] code);
    logic [1:0] r;
    unique case (code)
      SZ_BYTE: r = 2'd0;
      SZ_HALF: r = 2'd1;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

endpackage

// ===== src/otde_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module otde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/otde_sequencer.sv =====
// Byte sequencer: walks a job through escape, header, mask, position and matrix bytes,
// or marker and tail bytes. Depends on otde_pkg; drives the registered output stream.
module otde_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  otde_pkg::job_t job,
  output logic           job_ready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // out_byte[7:0]
  output logic           m_axis_tlast    // last_byte
);

  import otde_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_ESC, SQ_HDR, SQ_MASK, SQ_PX, SQ_PY, SQ_PZ, SQ_MAT, SQ_FF, SQ_TAIL
  } phase_t;

  phase_t                 phase, ph_next;
  job_t                   job_q;
  logic [1:0]             k, k_next;
  logic [NUM_ENTRIES-1:0] mat_pend, pend_next, pend_after;
  logic [3:0]             sel;
  logic [15:0]            dm_sel;
  logic [7:0]             cur_byte;
  logic [1:0]             cx, cy, cz;
  logic                   adv;
  phase_t                 after_mask, after_x, after_y, after_z;

  assign job_ready = (phase == SQ_IDLE);
  assign adv       = !m_axis_tvalid || m_axis_tready;

  assign cx = job_q.mask[1:0];
  assign cy = job_q.mask[3:2];
  assign cz = job_q.mask[5:4];

  assign after_z    = (mat_pend != '0) ? SQ_MAT : SQ_IDLE;
  assign after_y    = (cz != SZ_NONE) ? SQ_PZ : after_z;
  assign after_x    = (cy != SZ_NONE) ? SQ_PY : after_y;
  assign after_mask = (cx != SZ_NONE) ? SQ_PX : after_x;

  // Lowest pending matrix entry goes out first.
  always_comb begin
    sel = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (mat_pend[i]) sel = 4'(i);
    end
  end

  assign dm_sel     = job_q.dm[sel];
  assign pend_after = mat_pend & ~(NUM_ENTRIES'(1) << sel);

  always_comb begin
    cur_byte  = '0;
    ph_next   = phase;
    k_next    = k;
    pend_next = mat_pend;
    unique case (phase)
      SQ_IDLE: begin
      end
      SQ_ESC: begin
        cur_byte = job_q.esc_byte;
        ph_next  = SQ_HDR;
      end
      SQ_HDR: begin
        cur_byte = job_q.hdr_byte;
        k_next   = '0;
        ph_next  = (job_q.masklen != 2'd0) ? SQ_MASK : SQ_IDLE;
      end
      SQ_MASK: begin
        cur_byte = k[0] ? job_q.mask[15:8] : job_q.mask[7:0];
        if (2'(k + 2'd1) < job_q.masklen) begin
          k_next = 2'(k + 2'd1);
        end else begin
          k_next  = '0;
          ph_next = after_mask;
        end
      end
      SQ_PX: begin
        cur_byte = byte_of(job_q.wx, k);
        if (k == last_k(cx)) begin
          k_next  = '0;
          ph_next = after_x;
        end else begin
          k_next = 2'(k + 2'd1);
        end
      end
      SQ_PY: begin
        cur_byte = byte_of(job_q.wy, k);
        if (k == last_k(cy)) begin
          k_next  = '0;
          ph_next = after_y;
        end else begin
          k_next = 2'(k + 2'd1);
        end
      end
      SQ_PZ: begin
        cur_byte = byte_of(job_q.wz, k);
        if (k == last_k(cz)) begin
          k_next  = '0;
          ph_next = after_z;
        end else begin
          k_next = 2'(k + 2'd1);
        end
      end
      SQ_MAT: begin
        cur_byte = k[0] ? dm_sel[15:8] : dm_sel[7:0];
        if (job_q.wide && !k[0]) begin
          k_next = 2'd1;
        end else begin
          k_next    = '0;
          pend_next = pend_after;
          ph_next   = (pend_after != '0) ? SQ_MAT : SQ_IDLE;
        end
      end
      SQ_FF: begin
        cur_byte = MARK_BYTE;
        ph_next  = SQ_TAIL;
      end
      SQ_TAIL: begin
        cur_byte = job_q.tail_byte;
        ph_next  = SQ_IDLE;
      end
      default: begin
        ph_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= SQ_IDLE;
      k             <= '0;
      mat_pend      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (phase == SQ_IDLE) begin
        if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
        if (job_valid) begin
          job_q    <= job;
          mat_pend <= job.mask[15:7];
          k        <= '0;
          if (!job.is_commit) phase <= SQ_FF;
          else if (job.esc_need) phase <= SQ_ESC;
          else phase <= SQ_HDR;
        end
      end else if (adv) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= cur_byte;
        m_axis_tlast  <= (ph_next == SQ_IDLE);
        phase         <= ph_next;
        k             <= k_next;
        mat_pend      <= pend_next;
      end
    end
  end

  a_job_starts: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> phase != SQ_IDLE)
    else $error("job taken but sequencer stayed idle");

  a_mat_pending: assert property (@(posedge clk) disable iff (rst)
    phase == SQ_MAT |-> mat_pend != '0)
    else $error("matrix phase with no pending entry");

  a_mask_len: assert property (@(posedge clk) disable iff (rst)
    phase == SQ_MASK |-> k < job_q.masklen)
    else $error("mask byte counter beyond mask length");

endmodule

// ===== src/object_transform_delta_encoder_top.sv =====
// Top level of the object transform delta encoder: intake, state memory, delta logic.
// Depends on otde_pkg, otde_ram and otde_sequencer.
// With the byte sequencer idle, an accepted transaction passes the working stage and the
// sequencer's job register before its first output byte is registered and presented.
// Throughput: a commit holds the sequencer until its last byte is out; staging items and
// silent commits pass at one per cycle unless a job waits; the output port sets the pace.
// Reset (synchronous, active high) starts a clearing pass over all NUM_OBJECTS entries of the
// object memory; no input transaction is accepted until it ends. Configuration is taken as ever.
module object_transform_delta_encoder_top #(
  parameter int NUM_OBJECTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, lowest bit up: obj_index[9:0], visible[10], entry_index[14:11],
  // entry_value[30:15], pos_x[62:31], pos_y[94:63], pos_z[126:95], zero[127]
  input  logic [otde_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                      s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // out_byte[7:0]
  output logic                            m_axis_tlast,   // last_byte
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [otde_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import otde_pkg::*;

  localparam int AW = $clog2(NUM_OBJECTS);
  localparam int EW = $bits(entry_t);

  // Configuration register: field of view in degrees.
  logic [7:0]  fov;
  logic [22:0] fov_prod;
  logic [7:0]  fov_byte;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FOV) ? {24'd0, fov} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fov <= FOV_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_FOV) begin
      fov <= pwdata[7:0];
    end
  end

  // Division by 360/256 done as a multiply by a scaled reciprocal.
  assign fov_prod = 23'(fov) * 23'(FOV_RECIP);
  assign fov_byte = fov_prod[FOV_SHIFT +: 8];

  // Clearing pass over the object memory after reset.
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(NUM_OBJECTS - 1)) clr_active <= 1'b0;
      clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  // Single working stage: the memory read is issued when a transaction is accepted,
  // the read data is used the cycle after, and a commit that emits bytes writes its entry back
  // when the stage retires. A write that lands on the same edge as the read is forwarded.
  logic                         s1_valid, s1_done, s1_hit;
  req_t                         s1_req;
  logic [9:0]                   s1_idx;
  logic                         s1_vis;
  logic [3:0]                   s1_eidx;
  logic [15:0]                  s1_eval;
  logic [31:0]                  s1_px, s1_py, s1_pz;
  logic [NUM_ENTRIES-1:0][15:0] staged;
  logic [9:0]                   last_idx;
  entry_t                       fwd_q;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [9:0]    in_idx;

  assign in_idx        = s_axis_tdata[9:0];
  assign s_axis_tready = !clr_active && (!s1_valid || s1_done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  otde_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_OBJECTS)
  ) u_obj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Delta computation on the stored entry.
  entry_t                       ent, new_ent;
  logic                         cam, vis_eff, prev_vis, in_range;
  logic [31:0]                  dx, dy, dz;
  logic [NUM_ENTRIES-1:0]       chg;
  logic                         wide;
  logic [NUM_ENTRIES-1:0][15:0] dm;
  logic signed [16:0]           d17;
  logic [15:0]                  mask;
  logic [1:0]                   masklen, ml_eff;
  logic                         appear, disappear, emit_any, commit_ok, needs_seq;
  job_t                         job;
  logic                         job_ready;

  assign ent      = s1_hit ? fwd_q : entry_t'(ram_rdata);
  assign cam      = (s1_idx == 10'd0);
  assign vis_eff  = cam || s1_vis;
  assign prev_vis = cam || ent.vis;
  assign in_range = ({1'b0, s1_idx} < 11'(NUM_OBJECTS));

  assign dx = s1_px - ent.px;
  assign dy = s1_py - ent.py;
  assign dz = s1_pz - ent.pz;

  always_comb begin
    wide = 1'b0;
    chg  = '0;
    dm   = '0;
    d17  = '0;
    for (int a = 0; a < NUM_ENTRIES; a++) begin
      d17   = $signed({staged[a][15], staged[a]}) - $signed({ent.mat[a][15], ent.mat[a]});
      dm[a] = d17[15:0];
      chg[a] = (d17 != 17'sd0);
      if (d17 < -17'sd127 || d17 > 17'sd127) wide = 1'b1;
    end
  end

  assign mask = {chg, wide, size_code(dz), size_code(dy), size_code(dx)};
  assign masklen = (mask == 16'd0) ? 2'd0 : (mask[15:8] == 8'd0) ? 2'd1 : 2'd2;
  assign ml_eff    = vis_eff ? masklen : 2'd0;
  assign appear    = vis_eff && !prev_vis;
  assign disappear = !vis_eff && prev_vis;
  assign emit_any  = appear || disappear || (ml_eff != 2'd0);
  assign commit_ok = (s1_req == REQ_COMMIT) && in_range && emit_any;
  assign needs_seq = commit_ok || (s1_req == REQ_FRAME) || (s1_req == REQ_STREAM);
  assign s1_done   = s1_valid && (!needs_seq || job_ready);

  always_comb begin
    job           = '0;
    job.is_commit = (s1_req == REQ_COMMIT);
    job.esc_need  = (s1_idx[9:4] != last_idx[9:4]);
    job.esc_byte  = {ESC_TAG, s1_idx[9:4]};
    job.hdr_byte  = {appear, disappear, ml_eff, s1_idx[3:0]};
    job.masklen   = ml_eff;
    job.mask      = mask;
    job.wx        = dx;
    job.wy        = dy;
    job.wz        = dz;
    job.wide      = wide;
    job.dm        = dm;
    job.tail_byte = (s1_req == REQ_FRAME) ? fov_byte : MARK_BYTE;
  end

  assign new_ent.vis = vis_eff;
  assign new_ent.px  = s1_px;
  assign new_ent.py  = s1_py;
  assign new_ent.pz  = s1_pz;
  assign new_ent.mat = staged;

  assign ram_we    = clr_active || (s1_done && commit_ok);
  assign ram_waddr = clr_active ? clr_addr : s1_idx[AW-1:0];
  assign ram_wdata = clr_active ? entry_t'('0) : new_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_hit   <= 1'b0;
      staged   <= '0;
      last_idx <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_hit   <= ram_we && (ram_waddr == in_idx[AW-1:0]);
        s1_req   <= req_t'(s_axis_tuser);
        s1_idx   <= in_idx;
        s1_vis   <= s_axis_tdata[10];
        s1_eidx  <= s_axis_tdata[14:11];
        s1_eval  <= s_axis_tdata[30:15];
        s1_px    <= s_axis_tdata[62:31];
        s1_py    <= s_axis_tdata[94:63];
        s1_pz    <= s_axis_tdata[126:95];
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        if (s1_req == REQ_STAGE && s1_eidx < 4'(NUM_ENTRIES)) begin
          staged[s1_eidx] <= s1_eval;
        end
        if (commit_ok) last_idx <= s1_idx;
        if (s1_req == REQ_FRAME) last_idx <= '0;
      end
    end
  end

  // Copy of the last entry written, for a read issued on the same edge.
  always_ff @(posedge clk) begin
    if (ram_we) fwd_q <= ram_wdata;
  end

  otde_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (s1_valid && needs_seq),
    .job           (job),
    .job_ready     (job_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("input taken during memory clearing pass");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> clr_active || s1_done)
    else $error("memory written outside clearing or stage retirement");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_done |=> s1_valid && $stable(s1_idx) && $stable(s1_req))
    else $error("stalled working stage lost its transaction");

endmodule

// ===== test/tb_object_transform_delta_encoder_top.sv =====
// Testbench for object_transform_delta_encoder_top: random and directed frames of staging,
// commits, frame ends and stream ends, with bytes predicted and checked in order.
// Depends on otde_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_object_transform_delta_encoder_top;
  import otde_pkg::*;

  localparam int NOBJ = 256;
  localparam int WATCH_LIMIT = 20000;

  // One input transaction as the driver presents it.
  typedef struct {
    req_t        req;
    logic [9:0]  obj;
    logic        vis;
    logic [3:0]  ent;
    logic [15:0] val;
    logic [31:0] px, py, pz;
  } item_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  object_transform_delta_encoder_top #(.NUM_OBJECTS(NOBJ)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the encoder's state, updated as each transaction is accepted.
  logic [7:0]         fov_shadow;
  logic signed [15:0] staged[9];
  logic               seen[NOBJ];
  logic [31:0]        old_x[NOBJ], old_y[NOBJ], old_z[NOBJ];
  logic signed [15:0] old_m[NOBJ][9];
  logic [9:0]         last_idx;

  item_t        pending_items[$];
  stream_byte_t expected_bytes[$];
  int  errors = 0;
  int  send_idle = 30, recv_idle = 82;
  bit  recv_hold = 1'b0;
  int  watch = 0;

  function automatic logic [1:0] delta_size(logic signed [31:0] d);
    if (d == 0) return 2'd0;
    if (d >= -127 && d <= 127) return 2'd1;
    if (d >= -32767 && d <= 32767) return 2'd2;
    return 2'd3;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stream_byte_t e;
    e.b = b;
    e.last = 1'b0;
    expected_bytes.push_back(e);
  endtask

  task automatic push_sized(input logic [1:0] code, input logic [31:0] v);
    int n;
    n = (code == 2'd1) ? 1 : (code == 2'd2) ? 2 : (code == 2'd3) ? 4 : 0;
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8]);
  endtask

  // Works out the bytes one accepted transaction causes and updates the shadow state.
  task automatic encode_item(input item_t it);
    int   n_before;
    logic vis;
    logic [7:0] flag;
    logic [15:0] mask;
    logic [1:0] mlen;
    logic [31:0] wx, wy, wz;
    logic wide;
    int dm[9];
    n_before = expected_bytes.size();
    case (it.req)
      REQ_STAGE: if (it.ent < 9) staged[it.ent] = it.val;
      REQ_FRAME: begin
        push_byte(8'hFF);
        push_byte(8'((32'(fov_shadow) * 256) / 360));
        last_idx = '0;
      end
      REQ_STREAM: begin
        push_byte(8'hFF);
        push_byte(8'hFF);
      end
      default: if (it.obj < NOBJ) begin
        vis = it.vis;
        flag = '0; mask = '0; mlen = '0; wide = 1'b0;
        wx = '0; wy = '0; wz = '0;
        if (it.obj == 0) begin
          vis = 1'b1;
          seen[0] = 1'b1;
        end
        if (!vis) begin
          if (seen[it.obj]) begin
            flag = 8'h40;
            seen[it.obj] = 1'b0;
          end
        end else begin
          if (!seen[it.obj]) begin
            flag = 8'h80;
            seen[it.obj] = 1'b1;
          end
          wx = it.px - old_x[it.obj];
          wy = it.py - old_y[it.obj];
          wz = it.pz - old_z[it.obj];
          mask = {10'd0, delta_size(wz), delta_size(wy), delta_size(wx)};
          for (int a = 0; a < 9; a++) begin
            dm[a] = int'(staged[a]) - int'(old_m[it.obj][a]);
            if (dm[a] < -127 || dm[a] > 127) wide = 1'b1;
            if (dm[a] != 0) mask[7+a] = 1'b1;
          end
          if (wide) mask[6] = 1'b1;
          mlen = (mask == 0) ? 2'd0 : (mask[15:8] == 0) ? 2'd1 : 2'd2;
          flag = flag | (8'h10 * mlen);
        end
        if (flag != 0) begin
          if (it.obj[9:4] != last_idx[9:4]) push_byte(8'hC0 | 8'(it.obj >> 4));
          push_byte({4'd0, it.obj[3:0]} | flag);
          last_idx = it.obj;
          if (mlen != 0) begin
            for (int a = 0; a < mlen; a++) push_byte(mask[8*a +: 8]);
            push_sized(mask[1:0], wx);
            push_sized(mask[3:2], wy);
            push_sized(mask[5:4], wz);
            for (int a = 0; a < 9; a++) begin
              if (mask[7+a]) begin
                push_byte(dm[a][7:0]);
                if (wide) push_byte(dm[a][15:8]);
              end
            end
          end
          for (int a = 0; a < 9; a++) old_m[it.obj][a] = staged[a];
          old_x[it.obj] = it.px;
          old_y[it.obj] = it.py;
          old_z[it.obj] = it.pz;
        end
      end
    endcase
    if (expected_bytes.size() > n_before) expected_bytes[$].last = 1'b1;
  endtask

  // Driver: presents the head of the pending queue, lowering tvalid only on acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_item(pending_items.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          item_t it;
          it = pending_items[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.req;
          s_axis_tdata  <= {1'b0, it.pz, it.py, it.px, it.val, it.ent, it.vis, it.obj};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Only the head of the queue is ever on the bus; popping above keeps them in step,
  // because a new item is shown only in the same step the previous one is taken.

  // Monitor: checks each output transaction against the oldest expected byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          stream_byte_t e;
          e = expected_bytes.pop_front();
          if (e.b !== m_axis_tdata || e.last !== m_axis_tlast) begin
            $display("%0t: mismatch, expected %h last %b, actual %h last %b", $time,
                     e.b, e.last, m_axis_tdata, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no accepted transaction on either stream.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("tb_object_transform_delta_encoder_top failed");
      $finish;
    end
  end

  function automatic item_t make_item(req_t r, logic [9:0] o, logic v, logic [3:0] e,
                                      logic [15:0] val, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
    item_t it;
    it.req = r; it.obj = o; it.vis = v; it.ent = e; it.val = val;
    it.px = x; it.py = y; it.pz = z;
    return it;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(4))
      0: return 32'($urandom_range(0, 254)) - 127;
      1: return 32'($urandom_range(0, 65534)) - 32767;
      2: return $urandom();
      3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 254)) - 16'd127;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      2: return 16'd0;
      default: return 16'($urandom());
    endcase
  endfunction

  // A well-formed frame: staging, a run of commits on a few objects, then a frame or stream end.
  task automatic queue_frame();
    int n;
    logic [9:0] base;
    base = 10'($urandom_range(0, 15) * 16);
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      for (int s = $urandom_range(0, 4); s > 0; s--)
        pending_items.push_back(make_item(REQ_STAGE, 10'($urandom()), 1'($urandom_range(1)),
                                          4'($urandom_range(0, 9)), rand_entry(),
                                          $urandom(), $urandom(), $urandom()));
      pending_items.push_back(make_item(REQ_COMMIT,
                                        $urandom_range(9) == 0 ? 10'($urandom()) :
                                        base + 10'($urandom_range(0, 40)),
                                        $urandom_range(3) != 0, 4'($urandom()),
                                        16'($urandom()), rand_pos(), rand_pos(), rand_pos()));
    end
    pending_items.push_back(make_item($urandom_range(7) == 0 ? REQ_STREAM : REQ_FRAME,
                                      10'($urandom()), 1'($urandom_range(1)), 4'($urandom()),
                                      16'($urandom()), $urandom(), $urandom(), $urandom()));
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle; the shadow follows at the access edge.
  task automatic write_fov(input logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= REG_FOV; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    fov_shadow = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] fovs[5];
    fovs = '{8'd1, 8'd179, 8'd255, 8'd0, 8'd90};
    fov_shadow = FOV_RESET;
    for (int a = 0; a < 9; a++) staged[a] = '0;
    for (int i = 0; i < NOBJ; i++) begin
      seen[i] = 1'b0; old_x[i] = '0; old_y[i] = '0; old_z[i] = '0;
      for (int a = 0; a < 9; a++) old_m[i][a] = '0;
    end
    last_idx = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: reset FOV, the camera, appear, disappear, unchanged, escape,
    // out-of-range index and entry, wide matrix deltas, extreme positions, stream end.
    pending_items.push_back(make_item(REQ_FRAME, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 0, 0, 0, 0, 32'd5, 32'hFFFF_FF81,
                                      32'h8000_0000));
    pending_items.push_back(make_item(REQ_STAGE, 0, 0, 4'd0, 16'h7FFF, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STAGE, 0, 0, 4'd8, 16'h8000, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STAGE, 0, 0, 4'd9, 16'h1234, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STAGE, 0, 0, 4'd15, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd3, 1, 4'hF, 16'hFFFF, 32'h7FFF_FFFF,
                                      32'd32767, 32'hFFFF_8001));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd3, 1, 0, 0, 32'h7FFF_FFFF,
                                      32'd32767, 32'hFFFF_8001));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd3, 0, 0, 0, 1, 2, 3));
    pending_items.push_back(make_item(REQ_STAGE, 0, 0, 4'd4, 16'd100, 0, 0, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd255, 1, 0, 0, 32'd128, 32'd127, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd254, 1, 0, 0, 32'hFFFF_FFFF, 0, 0));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd256, 1, 0, 0, 7, 7, 7));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd1023, 1, 0, 0, 7, 7, 7));
    pending_items.push_back(make_item(REQ_COMMIT, 10'd20, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_STREAM, 10'h3FF, 1, 4'hF, 16'hFFFF, '1, '1, '1));
    wait_drained();

    // Random phases with several FOV settings and the three idling patterns.
    for (int ph = 0; ph < 5; ph++) begin
      write_fov(fovs[ph]);
      if (ph == 2) begin send_idle = 82; recv_idle = 30; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      while (pending_items.size() < 52) queue_frame();
      if (ph == 1) begin
        // Long receiver hold-off while the sender keeps offering.
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      wait_drained();
    end
    wait_drained();
    if (errors == 0) $display("tb_object_transform_delta_encoder_top passed");
    else $display("tb_object_transform_delta_encoder_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/otde_pkg.sv
src/otde_ram.sv
src/otde_sequencer.sv
src/object_transform_delta_encoder_top.sv
test/tb_object_transform_delta_encoder_top.sv
